>>> rtl/assert_macros.svh
// Assertion macros used by the checker of the neighborhood count unit.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/wnsc_pkg.sv
// Package for the weighted neighborhood state count unit: transaction types,
// command and register codes, and fixed field widths. Depends on nothing.
package wnsc_pkg;

   // Fixed field widths.
   localparam int CMD_W        = 2;
   localparam int COORD_W      = 6;
   localparam int CELL_STATE_W = 3;
   localparam int KIDX_W       = 3;
   localparam int WEIGHT_W     = 8;
   localparam int SUM_W        = 14;
   localparam int STATE_VALUES = 2 ** CELL_STATE_W;

   // Configuration port shape.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   // Saturation value of a weighted count.
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_WRITE_CELL   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_KERNEL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY        = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_ROWS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_COLS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WRAP_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STATE_COUNT = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [COORD_W-1:0]      row;
      logic [COORD_W-1:0]      col;
      logic [CELL_STATE_W-1:0] cell_state;
      logic [KIDX_W-1:0]       kernel_row;
      logic [KIDX_W-1:0]       kernel_col;
      logic [WEIGHT_W-1:0]     kernel_weight;
   } req_type;

   typedef struct packed {
      logic [CELL_STATE_W-1:0] state_index;
      logic [SUM_W-1:0]        weighted_count;
      logic                    last;
   } rsp_type;

endpackage

>>> rtl/weighted_neighbourhood_state_count_unit.sv
// Top level of the weighted neighborhood state count unit: grid and kernel
// memories, query sequencer and per-state sum lanes. Depends on wnsc_pkg.
//
// Usage:
//   The req channel carries one transaction per command: a cell write, a
//   kernel weight write or a query. Writes keep the block idle and give no result.
//   A query returns state_count rsp transactions, states in ascending order,
//   the final one flagged by last. Unknown commands are accepted and dropped.
//   A query runs six remainder steps for the wrapped start, a back-off
//   walk, then one grid memory read per kernel offset, which sets the
//   throughput (up to 49 reads for a 7x7 kernel), then one result per
//   cycle while the receiver takes them.
//   The block works on one query at a time; a new transaction is taken once
//   the final result sits in the output register.
//   When rsp_ready is low the output register holds its transaction and the
//   sequencer waits in its emit state. Synchronous reset restores the register
//   defaults and idles the block; grid and kernel memories are not cleared.
//   The csr port writes a register at any edge with csr_we high; the user is
//   to write it only while the block is idle, which the block does not enforce.
module weighted_neighbourhood_state_count_unit #(
   parameter int MAX_ROWS       = 64,
   parameter int MAX_COLS       = 64,
   parameter int MAX_STATES     = 8,
   parameter int MAX_KERNEL_DIM = 7
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  wnsc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output wnsc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_we,
   input  logic [wnsc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wnsc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int GRID_AW    = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
   localparam int KERN_DEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
   localparam int KERN_AW    = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
   localparam int HALF_MAX   = (MAX_KERNEL_DIM - 1) / 2;
   localparam int SUM_LANES  = (MAX_STATES < wnsc_pkg::STATE_VALUES) ?
                               MAX_STATES : wnsc_pkg::STATE_VALUES;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MOD     = 3'd1;
   localparam logic [2:0] ST_BACKOFF = 3'd2;
   localparam logic [2:0] ST_SCAN    = 3'd3;
   localparam logic [2:0] ST_DRAIN   = 3'd4;
   localparam logic [2:0] ST_EMIT    = 3'd5;

   // Configuration registers.
   logic [6:0] grid_rows_ff;
   logic [6:0] grid_cols_ff;
   logic       wrap_ff;
   logic [1:0] half_height_ff;
   logic [1:0] half_width_ff;
   logic [3:0] state_count_ff;

   // Effective (clamped) configuration.
   logic [6:0] nr;
   logic [6:0] nc;
   logic [1:0] hh;
   logic [1:0] hw;
   logic [3:0] ns;

   // Sequencer.
   logic [2:0]        state_ff, state_in;
   logic [2:0]        div_cnt_ff, div_cnt_in;
   logic [5:0]        div_row_ff, div_row_in;
   logic [5:0]        div_col_ff, div_col_in;
   logic [6:0]        row_wrap_ff, row_wrap_in;
   logic [6:0]        col_wrap_ff, col_wrap_in;
   logic [6:0]        col_start_wrap_ff, col_start_wrap_in;
   logic signed [7:0] row_raw_ff, row_raw_in;
   logic signed [7:0] col_raw_ff, col_raw_in;
   logic signed [7:0] col_start_raw_ff, col_start_raw_in;
   logic [1:0]        back_row_ff, back_row_in;
   logic [1:0]        back_col_ff, back_col_in;
   logic [2:0]        kr_cnt_ff, kr_cnt_in;
   logic [2:0]        kc_cnt_ff, kc_cnt_in;
   logic [3:0]        emit_cnt_ff, emit_cnt_in;

   // Accumulate stage.
   logic                                acc_valid_ff, acc_valid_in;
   logic [wnsc_pkg::SUM_W-1:0]          sum_ff [SUM_LANES];
   logic [wnsc_pkg::SUM_W-1:0]          sum_in [SUM_LANES];

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   wnsc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Memories and their ports.
   logic [wnsc_pkg::CELL_STATE_W-1:0] grid_mem [GRID_DEPTH];
   logic [wnsc_pkg::WEIGHT_W-1:0]     kern_mem [KERN_DEPTH];
   logic [wnsc_pkg::CELL_STATE_W-1:0] grid_rd_ff;
   logic [wnsc_pkg::WEIGHT_W-1:0]     kern_rd_ff;
   logic                              grid_we;
   logic                              kern_we;
   logic [GRID_AW-1:0]                grid_waddr;
   logic [GRID_AW-1:0]                grid_raddr;
   logic [KERN_AW-1:0]                kern_waddr;
   logic [KERN_AW-1:0]                kern_raddr;

   logic req_fire;
   logic query_fire;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign query_fire = req_fire && (req_data.command == wnsc_pkg::CMD_QUERY);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Clamp the configuration to what the storage supports.
   always_comb begin
      if (grid_rows_ff == '0) begin
         nr = 7'd1;
      end else if (int'(grid_rows_ff) > MAX_ROWS) begin
         nr = 7'(MAX_ROWS);
      end else begin
         nr = grid_rows_ff;
      end
      if (grid_cols_ff == '0) begin
         nc = 7'd1;
      end else if (int'(grid_cols_ff) > MAX_COLS) begin
         nc = 7'(MAX_COLS);
      end else begin
         nc = grid_cols_ff;
      end
      if (int'(half_height_ff) > HALF_MAX) begin
         hh = 2'(HALF_MAX);
      end else begin
         hh = half_height_ff;
      end
      if (int'(half_width_ff) > HALF_MAX) begin
         hw = 2'(HALF_MAX);
      end else begin
         hw = half_width_ff;
      end
      if (state_count_ff == '0) begin
         ns = 4'd1;
      end else if (int'(state_count_ff) > MAX_STATES) begin
         ns = 4'(MAX_STATES);
      end else begin
         ns = state_count_ff;
      end
   end

   // Configuration writes; indexes beyond the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff   <= 7'd64;
         grid_cols_ff   <= 7'd64;
         wrap_ff        <= 1'b0;
         half_height_ff <= 2'd1;
         half_width_ff  <= 2'd1;
         state_count_ff <= 4'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            wnsc_pkg::REG_GRID_ROWS:   grid_rows_ff   <= csr_wdata;
            wnsc_pkg::REG_GRID_COLS:   grid_cols_ff   <= csr_wdata;
            wnsc_pkg::REG_WRAP_ENABLE: wrap_ff        <= csr_wdata[0];
            wnsc_pkg::REG_HALF_HEIGHT: half_height_ff <= csr_wdata[1:0];
            wnsc_pkg::REG_HALF_WIDTH:  half_width_ff  <= csr_wdata[1:0];
            wnsc_pkg::REG_STATE_COUNT: state_count_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // Write ports: out-of-range cell and kernel writes are dropped.
   always_comb begin
      grid_we = req_fire && (req_data.command == wnsc_pkg::CMD_WRITE_CELL) &&
                (int'(req_data.row) < MAX_ROWS) && (int'(req_data.col) < MAX_COLS);
      kern_we = req_fire && (req_data.command == wnsc_pkg::CMD_WRITE_KERNEL) &&
                (int'(req_data.kernel_row) < MAX_KERNEL_DIM) &&
                (int'(req_data.kernel_col) < MAX_KERNEL_DIM);
      grid_waddr = GRID_AW'(req_data.row) * GRID_AW'(MAX_COLS) + GRID_AW'(req_data.col);
      kern_waddr = KERN_AW'(req_data.kernel_row) * KERN_AW'(MAX_KERNEL_DIM) +
                   KERN_AW'(req_data.kernel_col);
   end

   // Read ports for the current kernel offset; off-grid neighbors are masked.
   logic       in_grid;
   logic [6:0] tr;
   logic [6:0] tc;

   always_comb begin
      in_grid = wrap_ff ||
                ((row_raw_ff >= 8'sd0) && (row_raw_ff < $signed({1'b0, nr})) &&
                 (col_raw_ff >= 8'sd0) && (col_raw_ff < $signed({1'b0, nc})));
      tr = wrap_ff ? row_wrap_ff : row_raw_ff[6:0];
      tc = wrap_ff ? col_wrap_ff : col_raw_ff[6:0];
      acc_valid_in = (state_ff == ST_SCAN) && in_grid;
      grid_raddr = acc_valid_in ? (GRID_AW'(tr) * GRID_AW'(MAX_COLS) + GRID_AW'(tc)) : '0;
      kern_raddr = KERN_AW'(kr_cnt_ff) * KERN_AW'(MAX_KERNEL_DIM) + KERN_AW'(kc_cnt_ff);
   end

   // Grid memory with registered read.
   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= req_data.cell_state;
      end
      grid_rd_ff <= grid_mem[grid_raddr];
   end

   // Kernel weight memory with registered read.
   always_ff @(posedge clock) begin
      if (kern_we) begin
         kern_mem[kern_waddr] <= req_data.kernel_weight;
      end
      kern_rd_ff <= kern_mem[kern_raddr];
   end

   // Sequencer: remainder steps, back-off walk, kernel scan and result emission.
   // Sum lanes add and write back in the same cycle: back-to-back hits need no bypass.
   always_comb begin
      logic [7:0]                 tmp_r;
      logic [7:0]                 tmp_c;
      logic                       row_end;
      logic                       load;
      logic [wnsc_pkg::SUM_W:0]   acc;

      state_in          = state_ff;
      div_cnt_in        = div_cnt_ff;
      div_row_in        = div_row_ff;
      div_col_in        = div_col_ff;
      row_wrap_in       = row_wrap_ff;
      col_wrap_in       = col_wrap_ff;
      col_start_wrap_in = col_start_wrap_ff;
      row_raw_in        = row_raw_ff;
      col_raw_in        = col_raw_ff;
      col_start_raw_in  = col_start_raw_ff;
      back_row_in       = back_row_ff;
      back_col_in       = back_col_ff;
      kr_cnt_in         = kr_cnt_ff;
      kc_cnt_in         = kc_cnt_ff;
      emit_cnt_in       = emit_cnt_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_data_in       = rsp_data_ff;
      tmp_r             = {row_wrap_ff, div_row_ff[5]};
      tmp_c             = {col_wrap_ff, div_col_ff[5]};
      row_end           = (kc_cnt_ff == {hw, 1'b0});
      load              = !rsp_valid_ff || rsp_ready;

      // Accumulate the weight of the neighbor read in the previous cycle.
      for (int i = 0; i < SUM_LANES; i++) begin
         acc = {1'b0, sum_ff[i]} + {{(wnsc_pkg::SUM_W + 1 - wnsc_pkg::WEIGHT_W){1'b0}},
                                    kern_rd_ff};
         sum_in[i] = sum_ff[i];
         if (acc_valid_ff && ({1'b0, grid_rd_ff} < ns) &&
             (grid_rd_ff == wnsc_pkg::CELL_STATE_W'(i))) begin
            sum_in[i] = acc[wnsc_pkg::SUM_W] ? wnsc_pkg::SUM_MAX : acc[wnsc_pkg::SUM_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            // A query latches its centre and clears the sums.
            if (query_fire) begin
               state_in         = ST_MOD;
               div_cnt_in       = '0;
               div_row_in       = req_data.row;
               div_col_in       = req_data.col;
               row_wrap_in      = '0;
               col_wrap_in      = '0;
               row_raw_in       = $signed({2'b00, req_data.row}) - $signed({6'd0, hh});
               col_raw_in       = $signed({2'b00, req_data.col}) - $signed({6'd0, hw});
               col_start_raw_in = $signed({2'b00, req_data.col}) - $signed({6'd0, hw});
               back_row_in      = hh;
               back_col_in      = hw;
               kr_cnt_in        = '0;
               kc_cnt_in        = '0;
               emit_cnt_in      = '0;
               for (int i = 0; i < SUM_LANES; i++) begin
                  sum_in[i] = '0;
               end
            end
         end
         ST_MOD: begin
            // One restoring remainder step per cycle for row and column.
            row_wrap_in = (tmp_r >= {1'b0, nr}) ? 7'(tmp_r - {1'b0, nr}) : tmp_r[6:0];
            col_wrap_in = (tmp_c >= {1'b0, nc}) ? 7'(tmp_c - {1'b0, nc}) : tmp_c[6:0];
            div_row_in  = {div_row_ff[4:0], 1'b0};
            div_col_in  = {div_col_ff[4:0], 1'b0};
            div_cnt_in  = div_cnt_ff + 3'd1;
            if (div_cnt_ff == 3'(wnsc_pkg::COORD_W - 1)) begin
               state_in = ST_BACKOFF;
            end
         end
         ST_BACKOFF: begin
            // Step the wrapped centre back to the kernel's top-left corner.
            if ((back_row_ff == '0) && (back_col_ff == '0)) begin
               col_start_wrap_in = col_wrap_ff;
               state_in          = ST_SCAN;
            end
            if (back_row_ff != '0) begin
               row_wrap_in = (row_wrap_ff == '0) ? (nr - 7'd1) : (row_wrap_ff - 7'd1);
               back_row_in = back_row_ff - 2'd1;
            end
            if (back_col_ff != '0) begin
               col_wrap_in = (col_wrap_ff == '0) ? (nc - 7'd1) : (col_wrap_ff - 7'd1);
               back_col_in = back_col_ff - 2'd1;
            end
         end
         ST_SCAN: begin
            // Walk the kernel window in row-major order, one offset per cycle.
            if (row_end) begin
               kc_cnt_in   = '0;
               col_raw_in  = col_start_raw_ff;
               col_wrap_in = col_start_wrap_ff;
               kr_cnt_in   = kr_cnt_ff + 3'd1;
               row_raw_in  = row_raw_ff + 8'sd1;
               row_wrap_in = (row_wrap_ff == nr - 7'd1) ? 7'd0 : (row_wrap_ff + 7'd1);
               if (kr_cnt_ff == {hh, 1'b0}) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               kc_cnt_in   = kc_cnt_ff + 3'd1;
               col_raw_in  = col_raw_ff + 8'sd1;
               col_wrap_in = (col_wrap_ff == nc - 7'd1) ? 7'd0 : (col_wrap_ff + 7'd1);
            end
         end
         ST_DRAIN: begin
            // The last neighbor is accumulated in this cycle.
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Lane 0 goes out and the lanes shift down, zeros entering at the top.
            if (load) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.state_index    = emit_cnt_ff[wnsc_pkg::CELL_STATE_W-1:0];
               rsp_data_in.weighted_count = sum_ff[0];
               rsp_data_in.last           = (emit_cnt_ff == ns - 4'd1);
               emit_cnt_in                = emit_cnt_ff + 4'd1;
               for (int i = 0; i < SUM_LANES; i++) begin
                  if (i < SUM_LANES - 1) begin
                     sum_in[i] = sum_ff[i + 1];
                  end else begin
                     sum_in[i] = '0;
                  end
               end
               if (emit_cnt_ff == ns - 4'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_valid_ff <= acc_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      div_cnt_ff        <= div_cnt_in;
      div_row_ff        <= div_row_in;
      div_col_ff        <= div_col_in;
      row_wrap_ff       <= row_wrap_in;
      col_wrap_ff       <= col_wrap_in;
      col_start_wrap_ff <= col_start_wrap_in;
      row_raw_ff        <= row_raw_in;
      col_raw_ff        <= col_raw_in;
      col_start_raw_ff  <= col_start_raw_in;
      back_row_ff       <= back_row_in;
      back_col_ff       <= back_col_in;
      kr_cnt_ff         <= kr_cnt_in;
      kc_cnt_ff         <= kc_cnt_in;
      emit_cnt_ff       <= emit_cnt_in;
      rsp_data_ff       <= rsp_data_in;
      for (int i = 0; i < SUM_LANES; i++) begin
         sum_ff[i] <= sum_in[i];
      end
   end

endmodule

>>> rtl/wnsc_checker.sv
// Port-level checker for the weighted neighborhood state count unit and its bind.
// Depends on wnsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wnsc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input wnsc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wnsc_pkg::rsp_type rsp_data
);

   logic req_fire;
   logic query_fire;

   assign req_fire   = req_valid && req_ready;
   assign query_fire = req_fire && (req_data.command == wnsc_pkg::CMD_QUERY);

   // Reset empties the output register.
   `ASSERT_NEXT_CYCLE(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)

   // A stalled result transaction holds its payload.
   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                      rsp_valid && $stable(rsp_data))

   // While a non-final result is pending, no new transaction is taken.
   `ASSERT_SAME_CYCLE(a_busy_during_results, clock, reset, rsp_valid && !rsp_data.last,
                      !req_ready)

   // An accepted query occupies the block in the following cycle.
   `ASSERT_NEXT_CYCLE(a_query_busy, clock, reset, query_fire, !req_ready)

   // After any other transaction the block is ready again in the following cycle.
   `ASSERT_NEXT_CYCLE(a_write_single_cycle, clock, reset, req_fire && !query_fire, req_ready)

endmodule

bind weighted_neighbourhood_state_count_unit wnsc_checker u_wnsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> verif/weighted_neighbourhood_state_count_unit_test.sv
// Self-checking testbench for the weighted neighborhood state count unit.
// It keeps its own grid, kernel and register shadow to predict each query's per-state sums.
// Depends on wnsc_pkg and weighted_neighbourhood_state_count_unit.
`timescale 1ns / 100ps

module weighted_neighbourhood_state_count_unit_test;

   localparam int GRID_ROWS        = 64;
   localparam int GRID_COLS        = 64;
   localparam int KERNEL_DIM       = 7;
   localparam int DRAIN_CYCLES     = 80;
   localparam int SETTLE_LIMIT     = 20000;
   localparam int LONG_HOLD_CYCLES = 300;

   // The block accepts and drops this command.
   localparam logic [wnsc_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   wnsc_pkg::req_type                req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   wnsc_pkg::rsp_type                rsp_data;
   logic                             csr_we    = 1'b0;
   logic [wnsc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [wnsc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Register shadow, starting from the reset values.
   logic [6:0] cfg_rows   = 7'd64;
   logic [6:0] cfg_cols   = 7'd64;
   logic       cfg_wrap   = 1'b0;
   logic [1:0] cfg_hh     = 2'd1;
   logic [1:0] cfg_hw     = 2'd1;
   logic [3:0] cfg_states = 4'd2;

   // Grid and kernel shadow, with a record of which entries have been written.
   bit [wnsc_pkg::CELL_STATE_W-1:0] grid_mem [GRID_ROWS*GRID_COLS];
   bit                              cell_known [GRID_ROWS*GRID_COLS];
   bit [wnsc_pkg::WEIGHT_W-1:0]     weight_mem [KERNEL_DIM*KERNEL_DIM];
   bit                              weight_known [KERNEL_DIM*KERNEL_DIM];

   wnsc_pkg::rsp_type expected_counts [$];
   wnsc_pkg::rsp_type want_rsp;

   bit sender_idle_on   = 1'b1;
   bit receiver_idle_on = 1'b1;
   bit hold_request     = 1'b0;

   int mismatches      = 0;
   int items_sent      = 0;
   int queries_sent    = 0;
   int results_checked = 0;
   int settings_used   = 1;

   weighted_neighbourhood_state_count_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Ends a run that hangs.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Maps a kernel offset around a centre to a grid cell; returns 0 when the
   // neighbor lies outside the grid in use and edges do not wrap.
   function automatic bit locate_neighbour(input int r, c, dr, dc, output int tr, tc);
      int nr, nc;
      nr = clamp_int(int'(cfg_rows), 1, GRID_ROWS);
      nc = clamp_int(int'(cfg_cols), 1, GRID_COLS);
      tr = r + dr;
      tc = c + dc;
      if (cfg_wrap) begin
         tr = ((tr % nr) + nr) % nr;
         tc = ((tc % nc) + nc) % nc;
         return 1'b1;
      end
      return (tr >= 0 && tc >= 0 && tr < nr && tc < nc);
   endfunction

   // Sums the kernel weights per neighbor state and queues one result per state.
   function automatic void predict_state_counts(input int r, input int c);
      int                ns, hh, hw, dr, dc, tr, tc, st;
      int unsigned       sums [wnsc_pkg::STATE_VALUES];
      wnsc_pkg::rsp_type item;
      ns = clamp_int(int'(cfg_states), 1, wnsc_pkg::STATE_VALUES);
      hh = int'(cfg_hh);
      hw = int'(cfg_hw);
      foreach (sums[i]) sums[i] = 0;
      for (dr = -hh; dr <= hh; dr++) begin
         for (dc = -hw; dc <= hw; dc++) begin
            if (locate_neighbour(r, c, dr, dc, tr, tc)) begin
               st = int'(grid_mem[tr*GRID_COLS + tc]);
               // Neighbors in a state beyond the count in use add nothing.
               if (st < ns) begin
                  sums[st] += weight_mem[(dr + hh)*KERNEL_DIM + dc + hw];
                  if (sums[st] > wnsc_pkg::SUM_MAX) sums[st] = wnsc_pkg::SUM_MAX;
               end
            end
         end
      end
      for (int s = 0; s < ns; s++) begin
         item.state_index    = 3'(s);
         item.weighted_count = 14'(sums[s]);
         item.last           = (s == ns - 1);
         expected_counts.push_back(item);
      end
   endfunction

   // Applies one accepted transaction to the shadow state.
   function automatic void apply_to_model(input wnsc_pkg::req_type item);
      case (item.command)
         wnsc_pkg::CMD_WRITE_CELL: begin
            grid_mem[item.row*GRID_COLS + item.col]   = item.cell_state;
            cell_known[item.row*GRID_COLS + item.col] = 1'b1;
         end
         wnsc_pkg::CMD_WRITE_KERNEL: begin
            // Kernel positions past the table are dropped.
            if (item.kernel_row < KERNEL_DIM && item.kernel_col < KERNEL_DIM) begin
               weight_mem[item.kernel_row*KERNEL_DIM + item.kernel_col]   = item.kernel_weight;
               weight_known[item.kernel_row*KERNEL_DIM + item.kernel_col] = 1'b1;
            end
         end
         wnsc_pkg::CMD_QUERY: begin
            queries_sent++;
            predict_state_counts(int'(item.row), int'(item.col));
         end
         default: begin
         end
      endcase
   endfunction

   // Transaction builders; fields the command does not use carry random values.
   function automatic wnsc_pkg::req_type cell_write(input int r, input int c, input int s);
      wnsc_pkg::req_type item;
      item            = wnsc_pkg::req_type'($urandom);
      item.command    = wnsc_pkg::CMD_WRITE_CELL;
      item.row        = 6'(r);
      item.col        = 6'(c);
      item.cell_state = 3'(s);
      return item;
   endfunction

   function automatic wnsc_pkg::req_type weight_write(input int kr, input int kc, input int w);
      wnsc_pkg::req_type item;
      item               = wnsc_pkg::req_type'($urandom);
      item.command       = wnsc_pkg::CMD_WRITE_KERNEL;
      item.kernel_row    = 3'(kr);
      item.kernel_col    = 3'(kc);
      item.kernel_weight = 8'(w);
      return item;
   endfunction

   function automatic wnsc_pkg::req_type query_request(input int r, input int c);
      wnsc_pkg::req_type item;
      item         = wnsc_pkg::req_type'($urandom);
      item.command = wnsc_pkg::CMD_QUERY;
      item.row     = 6'(r);
      item.col     = 6'(c);
      return item;
   endfunction

   function automatic wnsc_pkg::req_type unknown_request();
      wnsc_pkg::req_type item;
      item         = wnsc_pkg::req_type'($urandom);
      item.command = CMD_UNKNOWN;
      return item;
   endfunction

   // Offers one transaction, after an optional idle burst, and waits for acceptance.
   task automatic send_item(input wnsc_pkg::req_type item);
      int gap;
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      apply_to_model(item);
   endtask

   // Writes the unwritten grid cells and kernel weights the query will read, then sends it.
   task automatic prepare_query(input int r, input int c);
      int dr, dc, tr, tc, kidx;
      for (dr = -int'(cfg_hh); dr <= int'(cfg_hh); dr++) begin
         for (dc = -int'(cfg_hw); dc <= int'(cfg_hw); dc++) begin
            kidx = (dr + cfg_hh)*KERNEL_DIM + dc + cfg_hw;
            if (!weight_known[kidx])
               send_item(weight_write(dr + cfg_hh, dc + cfg_hw, $urandom_range(0, 255)));
            if (locate_neighbour(r, c, dr, dc, tr, tc) && !cell_known[tr*GRID_COLS + tc])
               send_item(cell_write(tr, tc, $urandom_range(0, 7)));
         end
      end
      send_item(query_request(r, c));
   endtask

   // Stops offering, waits for every predicted result, then lets the block go idle.
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_counts.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_counts.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_counts.size());
         mismatches += expected_counts.size();
         expected_counts.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [wnsc_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [wnsc_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all six registers; only called while the block is idle.
   task automatic apply_config(input int rows, cols, wrap, hh, hw, ns);
      cfg_rows   = 7'(rows);
      cfg_cols   = 7'(cols);
      cfg_wrap   = 1'(wrap);
      cfg_hh     = 2'(hh);
      cfg_hw     = 2'(hw);
      cfg_states = 4'(ns);
      put_reg(wnsc_pkg::REG_GRID_ROWS, cfg_rows);
      put_reg(wnsc_pkg::REG_GRID_COLS, cfg_cols);
      put_reg(wnsc_pkg::REG_WRAP_ENABLE, 7'(cfg_wrap));
      put_reg(wnsc_pkg::REG_HALF_HEIGHT, 7'(cfg_hh));
      put_reg(wnsc_pkg::REG_HALF_WIDTH, 7'(cfg_hw));
      put_reg(wnsc_pkg::REG_STATE_COUNT, 7'(cfg_states));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // One transaction of the random mix: mostly queries, some cell and weight writes and noise.
   // Centers sit near the low corner, now and then near the high corner.
   task automatic random_transaction();
      int pick, r, c;
      pick = $urandom_range(0, 9);
      r = ($urandom_range(0, 7) == 0) ? $urandom_range(58, 63) : $urandom_range(0, 5);
      c = ($urandom_range(0, 7) == 0) ? $urandom_range(58, 63) : $urandom_range(0, 5);
      if (pick <= 5)
         prepare_query(r, c);
      else if (pick <= 7)
         send_item(cell_write(r, c, $urandom_range(0, 7)));
      else if (pick == 8)
         send_item(weight_write($urandom_range(0, 7), $urandom_range(0, 7),
                                $urandom_range(0, 255)));
      else
         send_item(unknown_request());
   endtask

   // Queries under the reset register values, at both grid corners, with extreme weights.
   task automatic test_reset_defaults();
      send_item(weight_write(0, 0, 255));
      send_item(weight_write(1, 1, 0));
      send_item(weight_write(2, 2, 255));
      send_item(cell_write(0, 0, 1));
      send_item(cell_write(1, 1, 0));
      prepare_query(0, 0);
      send_item(cell_write(63, 63, 1));
      prepare_query(63, 63);
      settle();
   endtask

   // Unknown command, kernel writes off the table and a state above the count in use.
   task automatic test_special_commands();
      send_item(unknown_request());
      send_item(weight_write(7, 1, 0));
      send_item(weight_write(1, 7, 0));
      send_item(weight_write(7, 7, 0));
      send_item(cell_write(62, 63, 7));
      send_item(cell_write(63, 62, 5));
      prepare_query(63, 63);
      settle();
   endtask

   // Register values at and past their ends, and wrapped queries centered off the grid.
   task automatic test_register_extremes();
      apply_config(0, 127, 1, 3, 0, 0);
      prepare_query(5, 63);
      settle();
      apply_config(127, 0, 0, 0, 3, 15);
      prepare_query(63, 0);
      prepare_query(10, 2);
      settle();
      apply_config(3, 5, 1, 2, 1, 8);
      prepare_query(63, 40);
      prepare_query(0, 0);
      settle();
      apply_config(1, 1, 0, 3, 3, 1);
      prepare_query(0, 0);
      settle();
   endtask

   // Random register settings, each followed by a burst of random transactions.
   task automatic test_random_phases();
      int rows, cols;
      for (int phase = 0; phase < 5; phase++) begin
         rows = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
         cols = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
         apply_config(rows, cols, $urandom_range(0, 1), $urandom_range(0, 3),
                      $urandom_range(0, 3), $urandom_range(0, 15));
         sender_idle_on   = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         repeat (10) random_transaction();
         settle();
      end
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while queries keep coming.
   task automatic test_backpressure();
      apply_config(6, 6, 1, 2, 2, 8);
      sender_idle_on = 1'b0;
      hold_request   = 1'b1;
      repeat (6) prepare_query($urandom_range(0, 63), $urandom_range(0, 63));
      settle();
      sender_idle_on = 1'b1;
   endtask

   // Full kernel and all states with neither side idling.
   task automatic test_no_idle();
      apply_config(8, 8, 1, 3, 3, 8);
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      repeat (12) random_transaction();
      settle();
   endtask

   // Result receiver: random stall bursts, and one long hold when requested.
   initial begin : receiver
      int pause;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
            pause = $urandom_range(1, 9);
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compares each accepted result with the oldest predicted one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual state %0d count %0d last %0d",
                     $time, rsp_data.state_index, rsp_data.weighted_count, rsp_data.last);
            mismatches++;
         end else begin
            want_rsp = expected_counts.pop_front();
            if (rsp_data.state_index !== want_rsp.state_index) begin
               $display("%0t: state_index mismatch, expected %0d, actual %0d",
                        $time, want_rsp.state_index, rsp_data.state_index);
               mismatches++;
            end
            if (rsp_data.weighted_count !== want_rsp.weighted_count) begin
               $display("%0t: weighted_count mismatch for state %0d, expected %0d, actual %0d",
                        $time, want_rsp.state_index, want_rsp.weighted_count,
                        rsp_data.weighted_count);
               mismatches++;
            end
            if (rsp_data.last !== want_rsp.last) begin
               $display("%0t: last mismatch for state %0d, expected %0d, actual %0d",
                        $time, want_rsp.state_index, want_rsp.last, rsp_data.last);
               mismatches++;
            end
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_special_commands();
      test_register_extremes();
      test_random_phases();
      test_backpressure();
      test_no_idle();
      $display("Run covered %0d transactions, %0d of them queries, over %0d register settings.",
               items_sent, queries_sent, settings_used);
      $display("Compared %0d per-state results with the predicted weighted counts.",
               results_checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> weighted_neighbourhood_state_count_unit.f
+incdir+rtl
rtl/wnsc_pkg.sv
rtl/weighted_neighbourhood_state_count_unit.sv
rtl/wnsc_checker.sv
verif/weighted_neighbourhood_state_count_unit_test.sv
